FILE: design/rclru_pkg.sv
// Package for the LRU row cache slot manager: command and register codes,
// controller states, and the command/status bundles between control and datapath.
// No dependencies.
package rclru_pkg;

  // Default build sizes
  localparam int MAX_ROWS_DEF  = 1024;
  localparam int MAX_SLOTS_DEF = 64;
  localparam int AGE_BITS_DEF  = 32;

  // Fixed field widths
  localparam int CNT_W      = 11;  // row request and row_count
  localparam int LIM_W      = 7;   // slot_limit
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_SLOT_W = 6;
  localparam int OUT_ROW_W  = 10;

  // Register reset values
  localparam logic [CNT_W-1:0] ROW_COUNT_RST  = 11'd1024;
  localparam logic [LIM_W-1:0] SLOT_LIMIT_RST = 7'd64;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NORM   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROWRD,
    ST_ROWCHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_EVICT,
    ST_ALLOC,
    ST_NORM,
    ST_NORM_END,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;      // request taken: latch folded row, clear result
    logic tick;         // advance the time stamp counter
    logic clr_step;     // row map clearing sweep, one entry
    logic fold_report;  // publish folded row in the result
    logic hit_report;   // publish resident slot in the result
    logic hit_refresh;  // restamp the resident slot
    logic scan_init;    // restart slot scan and its accumulators
    logic scan_rst;     // restart slot scan index only
    logic scan_step;    // visit one slot
    logic norm_wr;      // scan pass writes back normalised stamps
    logic pick_free;    // take the lowest free slot
    logic evict;        // drop the victim's row
    logic alloc;        // bind the folded row to the chosen slot
    logic set_full;     // no slot obtained
    logic out_load;     // move result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;
    logic row_hit;
    logic clr_last;
    logic scan_last;
    logic sl_zero;
    logic free_ok;
    logic victim_found;
    logic evict_fit;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/rclru_ctrl.sv
// Controller for the LRU row cache slot manager: sequences one request at a time.
// Depends on rclru_pkg for states and the command/status bundles.
module rclru_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rclru_pkg::CMD_W-1:0]   in_cmd,
  input  rclru_pkg::dp_stat_t           stat,
  output rclru_pkg::dp_cmd_t            cmd
);

  rclru_pkg::state_t                state_r, state_nxt;
  logic [rclru_pkg::CMD_W-1:0]      op_r, op_nxt;
  logic                             accept;

  assign accept = (state_r == rclru_pkg::ST_IDLE) && in_valid;

  // State and current command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rclru_pkg::ST_CLEAR;
      op_r    <= rclru_pkg::CMD_LOOKUP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign op_nxt = accept ? in_cmd : op_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rclru_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = rclru_pkg::ST_IDLE;
      end
      rclru_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd) inside
            rclru_pkg::CMD_LOOKUP, rclru_pkg::CMD_FILL: state_nxt = rclru_pkg::ST_ROWRD;
            rclru_pkg::CMD_TICK: state_nxt = rclru_pkg::ST_DONE;
            default: state_nxt = stat.sl_zero ? rclru_pkg::ST_DONE : rclru_pkg::ST_SCAN;
          endcase
        end
      end
      rclru_pkg::ST_ROWRD: state_nxt = rclru_pkg::ST_ROWCHK;
      rclru_pkg::ST_ROWCHK: begin
        if (!stat.in_range || stat.row_hit || op_r == rclru_pkg::CMD_LOOKUP) begin
          state_nxt = rclru_pkg::ST_DONE;
        end else begin
          state_nxt = stat.sl_zero ? rclru_pkg::ST_DECIDE : rclru_pkg::ST_SCAN;
        end
      end
      rclru_pkg::ST_SCAN: begin
        if (stat.scan_last) state_nxt = rclru_pkg::ST_SCAN_END;
      end
      rclru_pkg::ST_SCAN_END: begin
        state_nxt = (op_r == rclru_pkg::CMD_NORM) ? rclru_pkg::ST_NORM : rclru_pkg::ST_DECIDE;
      end
      rclru_pkg::ST_DECIDE: begin
        if (stat.free_ok)           state_nxt = rclru_pkg::ST_ALLOC;
        else if (stat.victim_found) state_nxt = rclru_pkg::ST_EVICT;
        else                        state_nxt = rclru_pkg::ST_DONE;
      end
      rclru_pkg::ST_EVICT: begin
        state_nxt = stat.evict_fit ? rclru_pkg::ST_ALLOC : rclru_pkg::ST_DONE;
      end
      rclru_pkg::ST_ALLOC: state_nxt = rclru_pkg::ST_DONE;
      rclru_pkg::ST_NORM: begin
        if (stat.scan_last) state_nxt = rclru_pkg::ST_NORM_END;
      end
      rclru_pkg::ST_NORM_END: state_nxt = rclru_pkg::ST_DONE;
      rclru_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = rclru_pkg::ST_IDLE;
      end
      default: state_nxt = rclru_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != rclru_pkg::ST_IDLE);
    unique case (state_r)
      rclru_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      rclru_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.tick      = (in_cmd == rclru_pkg::CMD_TICK);
          cmd.scan_init = (in_cmd == rclru_pkg::CMD_NORM);
        end
      end
      rclru_pkg::ST_ROWRD: cmd = '0;
      rclru_pkg::ST_ROWCHK: begin
        cmd.fold_report = stat.in_range;
        cmd.hit_report  = stat.in_range && stat.row_hit;
        cmd.hit_refresh = stat.in_range && stat.row_hit && (op_r == rclru_pkg::CMD_LOOKUP);
        cmd.scan_init   = stat.in_range && !stat.row_hit && (op_r == rclru_pkg::CMD_FILL);
      end
      rclru_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      rclru_pkg::ST_SCAN_END: cmd.scan_rst = (op_r == rclru_pkg::CMD_NORM);
      rclru_pkg::ST_DECIDE: begin
        cmd.pick_free = stat.free_ok;
        cmd.set_full  = !stat.free_ok && !stat.victim_found;
      end
      rclru_pkg::ST_EVICT: begin
        cmd.evict    = 1'b1;
        cmd.set_full = !stat.evict_fit;
      end
      rclru_pkg::ST_ALLOC: cmd.alloc = 1'b1;
      rclru_pkg::ST_NORM: begin
        cmd.scan_step = 1'b1;
        cmd.norm_wr   = 1'b1;
      end
      rclru_pkg::ST_NORM_END: cmd = '0;
      rclru_pkg::ST_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

  // A scan pass never starts over an empty slot range
  a_no_empty_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rclru_pkg::ST_SCAN || state_r == rclru_pkg::ST_NORM) |-> !stat.sl_zero)
    else $error("slot scan running with no usable slot");

endmodule

FILE: design/rclru_dp.sv
// Datapath for the LRU row cache slot manager: row map, slot map, age stamp
// memory, slot scan unit, configuration and result registers. Depends on rclru_pkg.
module rclru_dp #(
  parameter int MAX_ROWS  = rclru_pkg::MAX_ROWS_DEF,
  parameter int MAX_SLOTS = rclru_pkg::MAX_SLOTS_DEF,
  parameter int AGE_BITS  = rclru_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rclru_pkg::dp_cmd_t                  cmd,
  output rclru_pkg::dp_stat_t                 stat,
  input  logic [rclru_pkg::CNT_W-1:0]         in_row,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rclru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rclru_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic                                out_slot_valid,
  output logic [rclru_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic                                out_evicted_valid,
  output logic [rclru_pkg::OUT_ROW_W-1:0]     out_evicted_row,
  output logic [rclru_pkg::OUT_ROW_W-1:0]     out_folded_row,
  output logic                                out_full_error
);

  localparam int CNT_W  = rclru_pkg::CNT_W;
  localparam int LIM_W  = rclru_pkg::LIM_W;
  localparam int OSW    = rclru_pkg::OUT_SLOT_W;
  localparam int ORW    = rclru_pkg::OUT_ROW_W;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SL_W   = $clog2(MAX_SLOTS + 1);

  // Configuration
  logic [CNT_W-1:0] row_count_r;
  logic [LIM_W-1:0] slot_limit_r;

  // Request and result
  logic [CNT_W-1:0]  f_r;
  logic              in_range_r;
  logic              res_hit_r, res_slot_valid_r, res_ev_valid_r, res_full_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [ROW_W-1:0]  res_ev_row_r;
  logic [CNT_W-1:0]  res_folded_r;

  // Slot state
  logic [MAX_SLOTS-1:0] busy_r;
  logic [MAX_SLOTS-1:0] aval_r;
  logic [SL_W-1:0]      busy_count_r;
  logic [AGE_BITS-1:0]  now_time_r;

  // Memories
  logic [SLOT_W:0]      r2s_mem [MAX_ROWS];
  logic [SLOT_W:0]      r2s_rd_q;
  logic [ROW_W-1:0]     s2r_mem [MAX_SLOTS];
  logic [ROW_W-1:0]     s2r_rd_q;
  logic [AGE_BITS-1:0]  age_mem [MAX_SLOTS];
  logic [AGE_BITS-1:0]  age_rd_q;

  // Scan unit
  logic [SL_W-1:0]      scan_idx_r;
  logic [SLOT_W-1:0]    scan_slot;
  logic                 pipe_v_r, pipe_wr_r, pipe_busy_r, pipe_aval_r;
  logic [SLOT_W-1:0]    pipe_idx_r;
  logic                 free_found_r, victim_found_r;
  logic [SLOT_W-1:0]    free_idx_r, victim_r, alloc_r;
  logic [AGE_BITS-1:0]  least_r, mx_r, age_cur;

  logic [ROW_W-1:0]     clr_idx_r;

  // Output register
  logic                 out_valid_r;

  // Combinational helpers
  logic [CNT_W-1:0]     rc, fold;
  logic [CNT_W:0]       two_rc;
  logic                 in_lo, in_hi;
  logic [SL_W-1:0]      sl, bc_dec;
  logic                 r2s_we;
  logic [ROW_W-1:0]     r2s_wa;
  logic [SLOT_W:0]      r2s_wd;
  logic                 age_we;
  logic [SLOT_W-1:0]    age_wa;
  logic [AGE_BITS-1:0]  age_wd;
  logic                 out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  <= rclru_pkg::ROW_COUNT_RST;
      slot_limit_r <= rclru_pkg::SLOT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rclru_pkg::CFG_ROW_COUNT:  row_count_r  <= cfg_data;
        rclru_pkg::CFG_SLOT_LIMIT: slot_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row count, folding, effective slot count
  always_comb begin
    rc = row_count_r;
    if (row_count_r == '0) begin
      rc = CNT_W'(1);
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      rc = CNT_W'(MAX_ROWS);
    end
    two_rc = {1'b0, rc} << 1;
    in_lo  = (in_row < rc);
    in_hi  = ({1'b0, in_row} < two_rc);
    fold   = in_lo ? in_row : CNT_W'(two_rc - (CNT_W + 1)'(1) - {1'b0, in_row});
  end

  assign sl = (32'(slot_limit_r) > 32'(MAX_SLOTS)) ? SL_W'(MAX_SLOTS) : SL_W'(slot_limit_r);
  assign bc_dec = (busy_count_r == '0) ? '0 : busy_count_r - SL_W'(1);

  // Request latch and result assembly
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      f_r              <= fold;
      in_range_r       <= in_hi;
      res_hit_r        <= 1'b0;
      res_slot_valid_r <= 1'b0;
      res_slot_r       <= '0;
      res_ev_valid_r   <= 1'b0;
      res_ev_row_r     <= '0;
      res_folded_r     <= '0;
      res_full_r       <= 1'b0;
    end else begin
      if (cmd.fold_report) res_folded_r <= f_r;
      if (cmd.hit_report) begin
        res_hit_r        <= 1'b1;
        res_slot_valid_r <= 1'b1;
        res_slot_r       <= r2s_rd_q[SLOT_W-1:0];
      end
      if (cmd.evict) begin
        res_ev_valid_r <= 1'b1;
        res_ev_row_r   <= s2r_rd_q;
      end
      if (cmd.alloc) begin
        res_slot_valid_r <= 1'b1;
        res_slot_r       <= alloc_r;
      end
      if (cmd.set_full) res_full_r <= 1'b1;
    end
  end

  // Time stamp counter, slot occupancy, stamp valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_time_r   <= '0;
      busy_r       <= '0;
      aval_r       <= '0;
      busy_count_r <= '0;
    end else begin
      if (cmd.tick) now_time_r <= now_time_r + AGE_BITS'(1);
      if (cmd.alloc) begin
        busy_r[alloc_r] <= 1'b1;
        busy_count_r    <= busy_count_r + SL_W'(1);
      end else if (cmd.evict) begin
        busy_r[victim_r] <= 1'b0;
        busy_count_r     <= bc_dec;
      end
      if (age_we) aval_r[age_wa] <= 1'b1;
    end
  end

  // Row map write source
  always_comb begin
    r2s_we = 1'b0;
    r2s_wa = ROW_W'(f_r);
    r2s_wd = '0;
    if (cmd.clr_step) begin
      r2s_we = 1'b1;
      r2s_wa = clr_idx_r;
    end else if (cmd.evict) begin
      r2s_we = 1'b1;
      r2s_wa = s2r_rd_q;
    end else if (cmd.alloc) begin
      r2s_we = 1'b1;
      r2s_wd = {1'b1, alloc_r};
    end
  end

  // Row to slot map: {resident, slot}
  always_ff @(posedge clk) begin
    if (r2s_we) r2s_mem[r2s_wa] <= r2s_wd;
    r2s_rd_q <= r2s_mem[ROW_W'(f_r)];
  end

  // Slot to row map, read at the victim
  always_ff @(posedge clk) begin
    if (cmd.alloc) s2r_mem[alloc_r] <= ROW_W'(f_r);
    s2r_rd_q <= s2r_mem[victim_r];
  end

  // Clearing sweep over the row map after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + ROW_W'(1);
    end
  end

  // Age stamp of the slot in the evaluation stage; unwritten stamps read as zero
  assign age_cur = pipe_aval_r ? age_rd_q : '0;

  // Age memory write source
  always_comb begin
    age_we = 1'b0;
    age_wa = alloc_r;
    age_wd = now_time_r;
    if (cmd.hit_refresh) begin
      age_we = 1'b1;
      age_wa = r2s_rd_q[SLOT_W-1:0];
    end else if (cmd.alloc) begin
      age_we = 1'b1;
    end else if (pipe_v_r && pipe_wr_r) begin
      age_we = 1'b1;
      age_wa = pipe_idx_r;
      age_wd = age_cur - mx_r;
    end
  end

  assign scan_slot = scan_idx_r[SLOT_W-1:0];

  // Age stamp memory
  always_ff @(posedge clk) begin
    if (age_we) age_mem[age_wa] <= age_wd;
    age_rd_q <= age_mem[scan_slot];
  end

  // Scan control: index, issue stage, found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r     <= '0;
      pipe_v_r       <= 1'b0;
      pipe_wr_r      <= 1'b0;
      free_found_r   <= 1'b0;
      victim_found_r <= 1'b0;
    end else begin
      pipe_v_r  <= cmd.scan_step;
      pipe_wr_r <= cmd.norm_wr;
      if (cmd.scan_init) begin
        scan_idx_r     <= '0;
        free_found_r   <= 1'b0;
        victim_found_r <= 1'b0;
      end else if (cmd.scan_rst) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + SL_W'(1);
        if (!busy_r[scan_slot]) free_found_r <= 1'b1;
      end
      if (pipe_v_r && !pipe_wr_r && pipe_busy_r && $signed(age_cur) < $signed(least_r)) begin
        victim_found_r <= 1'b1;
      end
    end
  end

  // Scan payload: lowest free slot, oldest stamp, largest stamp
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      pipe_idx_r  <= scan_slot;
      pipe_busy_r <= busy_r[scan_slot];
      pipe_aval_r <= aval_r[scan_slot];
      if (!busy_r[scan_slot] && !free_found_r) free_idx_r <= scan_slot;
    end
    if (cmd.scan_init) begin
      least_r <= now_time_r + AGE_BITS'(1);
      mx_r    <= '0;
    end else if (pipe_v_r && !pipe_wr_r) begin
      if ($signed(age_cur) > $signed(mx_r)) mx_r <= age_cur;
      if (pipe_busy_r && $signed(age_cur) < $signed(least_r)) begin
        least_r  <= age_cur;
        victim_r <= pipe_idx_r;
      end
    end
    // slot choice: lowest free slot, or after eviction the lower of it and the victim
    if (cmd.pick_free) begin
      alloc_r <= free_idx_r;
    end else if (cmd.evict) begin
      alloc_r <= (free_found_r && free_idx_r < victim_r) ? free_idx_r : victim_r;
    end
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit           <= res_hit_r;
      out_slot_valid    <= res_slot_valid_r;
      out_slot          <= OSW'(res_slot_r);
      out_evicted_valid <= res_ev_valid_r;
      out_evicted_row   <= ORW'(res_ev_row_r);
      out_folded_row    <= ORW'(res_folded_r);
      out_full_error    <= res_full_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status
  always_comb begin
    stat              = '0;
    stat.in_range     = in_range_r;
    stat.row_hit      = r2s_rd_q[SLOT_W];
    stat.clr_last     = (clr_idx_r == ROW_W'(MAX_ROWS - 1));
    stat.scan_last    = (scan_idx_r == sl - SL_W'(1));
    stat.sl_zero      = (sl == '0);
    stat.free_ok      = free_found_r && (busy_count_r < sl);
    stat.victim_found = victim_found_r;
    stat.evict_fit    = (bc_dec < sl);
    stat.out_free     = out_free;
  end

  // Allocation only ever targets a free slot
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !busy_r[alloc_r])
    else $error("allocation into a busy slot");

  // Eviction only of a busy slot picked by the scan
  a_evict_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> (victim_found_r && busy_r[victim_r]))
    else $error("eviction of a slot that is not busy");

  // Occupancy count tracks the busy bits
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_count_r == SL_W'($countones(busy_r)))
    else $error("busy count out of step with busy bits");

endmodule

FILE: design/row_cache_lru_slot_manager_unit.sv
// LRU row cache slot manager, top level: controller plus datapath.
// After reset the row map is cleared, all MAX_ROWS entries (1024 by default), during
// which no request is taken; configuration writes are taken at any time. Requests
// are handled one at a time, each until its result enters the output register: a
// tick only advances the time stamp; lookup and fill read the row map; a fill of a
// new in-range row scans the usable slots for a free slot or the oldest busy one
// to evict; normalise scans the usable slots once for the largest stamp
// and again to subtract it from each stamp. The slot scans visit one slot per cycle
// through the single read port of the age stamp memory. A new request is taken in
// the cycle after its predecessor's result is registered, even while that
// result is stalled. Depends on rclru_pkg, rclru_ctrl and rclru_dp.
module row_cache_lru_slot_manager_unit #(
  parameter int MAX_ROWS  = rclru_pkg::MAX_ROWS_DEF,
  parameter int MAX_SLOTS = rclru_pkg::MAX_SLOTS_DEF,
  parameter int AGE_BITS  = rclru_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rclru_pkg::CMD_W-1:0]         in_cmd,
  input  logic [rclru_pkg::CNT_W-1:0]         in_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic                                out_slot_valid,
  output logic [rclru_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic                                out_evicted_valid,
  output logic [rclru_pkg::OUT_ROW_W-1:0]     out_evicted_row,
  output logic [rclru_pkg::OUT_ROW_W-1:0]     out_folded_row,
  output logic                                out_full_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rclru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rclru_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rclru_pkg::dp_cmd_t  cmd;
  rclru_pkg::dp_stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  rclru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  rclru_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_SLOTS (MAX_SLOTS),
    .AGE_BITS  (AGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_row            (in_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot_valid    (out_slot_valid),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_row   (out_evicted_row),
    .out_folded_row    (out_folded_row),
    .out_full_error    (out_full_error)
  );

endmodule

FILE: tb/tb_row_cache_lru_slot_manager_unit.sv
// Testbench for the LRU row cache slot manager: a directed table, then random request phases
// under changing register settings, checked against a local predictor or typed table results.
// Depends on rclru_pkg and row_cache_lru_slot_manager_unit.
`timescale 1ns / 100ps

module tb_row_cache_lru_slot_manager_unit;

  localparam int CMD_W         = rclru_pkg::CMD_W;
  localparam int CNT_W         = rclru_pkg::CNT_W;
  localparam int LIM_W         = rclru_pkg::LIM_W;
  localparam int CFG_IDX_W     = rclru_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = rclru_pkg::CFG_DATA_W;
  localparam int OUT_SLOT_W    = rclru_pkg::OUT_SLOT_W;
  localparam int OUT_ROW_W     = rclru_pkg::OUT_ROW_W;
  localparam int ROWS_N        = rclru_pkg::MAX_ROWS_DEF;
  localparam int SLOTS_N       = rclru_pkg::MAX_SLOTS_DEF;
  localparam int STAMP_W       = rclru_pkg::AGE_BITS_DEF;
  localparam int RANDOM_ITEMS  = 700;
  localparam int QUIET_LIMIT   = 10000;
  localparam int TAIL_CYCLES   = 2 * SLOTS_N + 40;

  typedef struct packed {
    logic                  hit;
    logic                  slot_valid;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evicted_valid;
    logic [OUT_ROW_W-1:0]  evicted_row;
    logic [OUT_ROW_W-1:0]  folded_row;
    logic                  full_error;
  } slot_report_t;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CMD_W-1:0]      cmd;
    logic [CNT_W-1:0]      row;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    slot_report_t          want;
  } plan_step_t;

  // Clock and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] in_cmd = rclru_pkg::CMD_LOOKUP;
  logic [CNT_W-1:0] in_row = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = rclru_pkg::CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_stall, out_valid, cfg_ready;
  logic out_hit, out_slot_valid, out_evicted_valid, out_full_error;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic [OUT_ROW_W-1:0]  out_evicted_row, out_folded_row;

  row_cache_lru_slot_manager_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_row            (in_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot_valid    (out_slot_valid),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_row   (out_evicted_row),
    .out_folded_row    (out_folded_row),
    .out_full_error    (out_full_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: row map, slot map, stamps and registers
  logic [LIM_W-1:0]   row_slot   [ROWS_N];
  logic [CNT_W-1:0]   slot_row   [SLOTS_N];
  logic               slot_used  [SLOTS_N];
  logic [STAMP_W-1:0] slot_stamp [SLOTS_N];
  logic [STAMP_W-1:0] clock_now;
  int                 used_count;
  logic [CNT_W-1:0]   reg_rows;
  logic [LIM_W-1:0]   reg_slots;

  slot_report_t reports_due [$];
  plan_step_t   plan [$];
  int           fail_count = 0;
  int           quiet_cycles = 0;

  function automatic void predictor_clear();
    int i;
    for (i = 0; i < ROWS_N; i++) row_slot[i] = '1;
    for (i = 0; i < SLOTS_N; i++) begin
      slot_row[i]   = '1;
      slot_used[i]  = 1'b0;
      slot_stamp[i] = '0;
    end
    clock_now  = '0;
    used_count = 0;
    reg_rows   = rclru_pkg::ROW_COUNT_RST;
    reg_slots  = rclru_pkg::SLOT_LIMIT_RST;
  endfunction

  function automatic int effective_rows();
    int rc;
    rc = int'(reg_rows);
    if (rc == 0) rc = 1;
    if (rc > ROWS_N) rc = ROWS_N;
    return rc;
  endfunction

  function automatic int effective_slots();
    return (reg_slots > SLOTS_N) ? SLOTS_N : int'(reg_slots);
  endfunction

  // Lowest free usable slot, only while the busy count is under the limit
  function automatic int claim_free_slot(input int sl);
    int k;
    if (used_count >= sl) return -1;
    for (k = 0; k < sl; k++) begin
      if (!slot_used[k]) begin
        slot_used[k] = 1'b1;
        used_count++;
        return k;
      end
    end
    return -1;
  endfunction

  // Next report of the slot manager for one request; updates the predictor state
  function automatic slot_report_t predict_slot_report(input logic [CMD_W-1:0] cmd,
                                                       input logic [CNT_W-1:0] row);
    slot_report_t rep;
    int sl, rc, f, s, pick, victim, k;
    logic [STAMP_W-1:0] mx, least;
    logic [CNT_W-1:0] old;
    rep = '0;
    sl = effective_slots();
    if (cmd == rclru_pkg::CMD_TICK) begin
      clock_now = clock_now + STAMP_W'(1);
      return rep;
    end
    if (cmd == rclru_pkg::CMD_NORM) begin
      mx = '0;
      for (k = 0; k < sl; k++)
        if ($signed(slot_stamp[k]) > $signed(mx)) mx = slot_stamp[k];
      for (k = 0; k < sl; k++) slot_stamp[k] = slot_stamp[k] - mx;
      return rep;
    end
    rc = effective_rows();
    if (int'(row) < rc) f = int'(row);
    else if (int'(row) < 2 * rc) f = 2 * rc - 1 - int'(row);
    else return rep;
    rep.folded_row = f[OUT_ROW_W-1:0];
    if (row_slot[f] < SLOTS_N) begin
      s = int'(row_slot[f]);
      rep.hit        = 1'b1;
      rep.slot_valid = 1'b1;
      rep.slot       = s[OUT_SLOT_W-1:0];
      if (cmd == rclru_pkg::CMD_LOOKUP) slot_stamp[s] = clock_now;
      return rep;
    end
    if (cmd == rclru_pkg::CMD_LOOKUP) return rep;
    pick = claim_free_slot(sl);
    if (pick < 0) begin
      // oldest busy usable slot stamped no later than now
      least  = clock_now + STAMP_W'(1);
      victim = -1;
      for (k = 0; k < sl; k++) begin
        if (slot_used[k] && $signed(slot_stamp[k]) < $signed(least)) begin
          least  = slot_stamp[k];
          victim = k;
        end
      end
      if (victim >= 0) begin
        old = slot_row[victim];
        slot_used[victim] = 1'b0;
        if (used_count > 0) used_count--;
        if (old < ROWS_N) row_slot[old] = '1;
        slot_row[victim] = '1;
        rep.evicted_valid = 1'b1;
        rep.evicted_row   = (old < ROWS_N) ? old[OUT_ROW_W-1:0] : '0;
        pick = claim_free_slot(sl);
      end
    end
    if (pick < 0) begin
      rep.full_error = 1'b1;
      return rep;
    end
    row_slot[f]      = pick[LIM_W-1:0];
    slot_row[pick]   = f[CNT_W-1:0];
    slot_stamp[pick] = clock_now;
    rep.slot_valid   = 1'b1;
    rep.slot         = pick[OUT_SLOT_W-1:0];
    return rep;
  endfunction

  function automatic slot_report_t report(input int hit, input int sv, input int slot,
                                          input int ev, input int erow, input int fold,
                                          input int full);
    slot_report_t rep;
    rep.hit           = hit[0];
    rep.slot_valid    = sv[0];
    rep.slot          = slot[OUT_SLOT_W-1:0];
    rep.evicted_valid = ev[0];
    rep.evicted_row   = erow[OUT_ROW_W-1:0];
    rep.folded_row    = fold[OUT_ROW_W-1:0];
    rep.full_error    = full[0];
    return rep;
  endfunction

  // Table builders
  function automatic void plan_req(input logic [CMD_W-1:0] cmd, input int row);
    plan.push_back('{STEP_REQ, cmd, row[CNT_W-1:0], rclru_pkg::CFG_ROW_COUNT, '0, 1'b0, '0});
  endfunction

  function automatic void plan_typed(input logic [CMD_W-1:0] cmd, input int row,
                                     input slot_report_t want);
    plan.push_back('{STEP_REQ, cmd, row[CNT_W-1:0], rclru_pkg::CFG_ROW_COUNT, '0, 1'b1, want});
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    plan.push_back('{STEP_CFG, rclru_pkg::CMD_LOOKUP, '0, idx, value[CFG_DATA_W-1:0], 1'b0,
                     '0});
  endfunction

  // Sender side
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] row,
                              input logic typed, input slot_report_t want);
    slot_report_t rep;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_row   <= row;
    do @(posedge clk); while (in_stall !== 1'b0);
    rep = predict_slot_report(cmd, row);
    reports_due.push_back(typed ? want : rep);
  endtask

  task automatic drain_reports();
    while (reports_due.size() != 0) pause_sender(1);
    pause_sender(4);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == rclru_pkg::CFG_ROW_COUNT) reg_rows = value[CNT_W-1:0];
    else if (idx == rclru_pkg::CFG_SLOT_LIMIT) reg_slots = value[LIM_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall pattern in one of four modes, redrawn at random
  int   stall_tick = 0;
  int   stall_mode = 0;
  int   run_left = 0;
  logic run_hold = 1'b0;

  always @(negedge clk) begin : stall_gen
    logic s;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0: s = 1'b0;
      1: s = ($urandom_range(0, 99) < 35);
      2: s = ((stall_tick % 9) < 4);
      default: begin
        if (run_left == 0) begin
          run_hold = !run_hold;
          run_left = $urandom_range(1, run_hold ? 40 : 12);
        end
        run_left--;
        s = run_hold;
      end
    endcase
    out_stall <= s;
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : report_check
    slot_report_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("slot_valid", 32'(want.slot_valid), 32'(out_slot_valid));
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("evicted_valid", 32'(want.evicted_valid), 32'(out_evicted_valid));
        check_field("evicted_row", 32'(want.evicted_row), 32'(out_evicted_row));
        check_field("folded_row", 32'(want.folded_row), 32'(out_folded_row));
        check_field("full_error", 32'(want.full_error), 32'(out_full_error));
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_row_cache_lru_slot_manager_unit: done, errors");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int i, n_items, phase_len, burst_left, rc, sl, ws_base, ws_size, f, pick;
    logic gaps_on;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] row;
    plan_step_t st;

    predictor_clear();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: reset values first, then extremes of both registers
    plan_typed(rclru_pkg::CMD_LOOKUP, 0, report(0, 0, 0, 0, 0, 0, 0));
    plan_typed(rclru_pkg::CMD_FILL, 0, report(0, 1, 0, 0, 0, 0, 0));
    plan_typed(rclru_pkg::CMD_FILL, 2047, report(1, 1, 0, 0, 0, 0, 0));   // folds onto row 0
    plan_typed(rclru_pkg::CMD_LOOKUP, 1023, report(0, 0, 0, 0, 0, 1023, 0));
    plan_typed(rclru_pkg::CMD_FILL, 1024, report(0, 1, 1, 0, 0, 1023, 0));
    plan_typed(rclru_pkg::CMD_TICK, 2047, report(0, 0, 0, 0, 0, 0, 0));
    plan_typed(rclru_pkg::CMD_LOOKUP, 0, report(1, 1, 0, 0, 0, 0, 0));
    plan_typed(rclru_pkg::CMD_NORM, 5, report(0, 0, 0, 0, 0, 0, 0));
    plan_cfg(rclru_pkg::CFG_ROW_COUNT, 2);
    plan_cfg(rclru_pkg::CFG_SLOT_LIMIT, 2);
    plan_typed(rclru_pkg::CMD_FILL, 4, report(0, 0, 0, 0, 0, 0, 0));      // beyond doubled range
    plan_typed(rclru_pkg::CMD_FILL, 3, report(1, 1, 0, 0, 0, 0, 0));
    plan_req(rclru_pkg::CMD_FILL, 1);                                     // evicts the oldest
    plan_req(rclru_pkg::CMD_TICK, 1365);
    plan_req(rclru_pkg::CMD_LOOKUP, 2);
    plan_cfg(rclru_pkg::CFG_ROW_COUNT, 2047);
    plan_cfg(rclru_pkg::CFG_SLOT_LIMIT, 1);
    plan_req(rclru_pkg::CMD_FILL, 7);                                     // evict, still no room
    plan_req(rclru_pkg::CMD_LOOKUP, 1);                                   // slot above the limit
    plan_cfg(rclru_pkg::CFG_SLOT_LIMIT, 0);
    plan_typed(rclru_pkg::CMD_FILL, 9, report(0, 0, 0, 0, 0, 9, 1));
    plan_typed(rclru_pkg::CMD_NORM, 0, report(0, 0, 0, 0, 0, 0, 0));
    plan_cfg(rclru_pkg::CFG_SLOT_LIMIT, 127);
    plan_cfg(rclru_pkg::CFG_ROW_COUNT, 0);
    plan_req(rclru_pkg::CMD_FILL, 1);
    plan_typed(rclru_pkg::CMD_LOOKUP, 2, report(0, 0, 0, 0, 0, 0, 0));
    plan_req(rclru_pkg::CMD_LOOKUP, 0);
    plan_req(rclru_pkg::CMD_FILL, 0);
    plan_cfg(rclru_pkg::CFG_ROW_COUNT, 1);
    plan_cfg(rclru_pkg::CFG_SLOT_LIMIT, 64);
    plan_req(rclru_pkg::CMD_TICK, 682);
    plan_req(rclru_pkg::CMD_NORM, 2046);

    foreach (plan[i]) begin
      st = plan[i];
      if (st.kind == STEP_CFG) begin
        drain_reports();
        write_reg(st.idx, st.value);
      end else begin
        send_request(st.cmd, st.row, st.typed, st.want);
      end
    end

    // Random phases, each after optional writes of freshly drawn register values
    n_items = 0;
    burst_left = 0;
    while (n_items < RANDOM_ITEMS) begin
      drain_reports();
      case ($urandom_range(0, 7))
        0: rc = 0;
        1: rc = 1;
        2: rc = 2047;
        3: rc = 1024;
        4, 5: rc = $urandom_range(2, 64);
        6: rc = $urandom_range(65, 1023);
        default: rc = $urandom_range(1025, 2046);
      endcase
      case ($urandom_range(0, 9))
        0: sl = 0;
        1: sl = 1;
        2: sl = 127;
        3: sl = 64;
        4: sl = $urandom_range(13, 126);
        default: sl = $urandom_range(2, 12);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(rclru_pkg::CFG_ROW_COUNT, rc[CFG_DATA_W-1:0]);
      if ($urandom_range(0, 3) != 0) write_reg(rclru_pkg::CFG_SLOT_LIMIT, sl[CFG_DATA_W-1:0]);

      // working set no smaller than the slot count and up to a little larger, so rows get evicted
      rc = effective_rows();
      sl = effective_slots();
      ws_size = sl + $urandom_range(0, sl / 2 + 3);
      if (ws_size < 1) ws_size = 1;
      ws_base = $urandom_range(0, rc - 1);
      phase_len = $urandom_range(30, 80);
      gaps_on = ($urandom_range(0, 3) != 0);

      for (i = 0; i < phase_len && n_items < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = rclru_pkg::CMD_FILL;
        else if (pick < 75) cmd = rclru_pkg::CMD_LOOKUP;
        else if (pick < 90) cmd = rclru_pkg::CMD_TICK;
        else cmd = rclru_pkg::CMD_NORM;
        if ($urandom_range(0, 9) == 0) begin
          row = CNT_W'($urandom_range(0, 2047));
        end else begin
          f = (ws_base + $urandom_range(0, ws_size - 1)) % rc;
          row = $urandom_range(0, 1) ? CNT_W'(2 * rc - 1 - f) : CNT_W'(f);
        end

        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (gaps_on) pause_sender($urandom_range(0, 8));
        end
        burst_left--;
        if ($urandom_range(0, 49) == 0) drain_reports();

        send_request(cmd, row, 1'b0, '0);
        n_items++;
      end
    end

    // Let the last results out, then a short tail
    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && reports_due.size() == 0)
      $display("tb_row_cache_lru_slot_manager_unit: done, clean");
    else
      $display("tb_row_cache_lru_slot_manager_unit: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/rclru_pkg.sv
design/rclru_ctrl.sv
design/rclru_dp.sv
design/row_cache_lru_slot_manager_unit.sv
tb/tb_row_cache_lru_slot_manager_unit.sv
